/* hdl/instruction_prefetch_with_cache_defines.svh */
// Assertion macros shared by the prefetch and cache RTL.
`ifndef INSTRUCTION_PREFETCH_WITH_CACHE_DEFINES_SVH
`define INSTRUCTION_PREFETCH_WITH_CACHE_DEFINES_SVH

`ifndef ASSERT_OFF

// The condition must hold at every clock edge outside reset.
`define IPC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define IPC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define IPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define IPC_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define IPC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define IPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* hdl/ipc_pkg.sv */
package ipc_pkg;

   // Number of cache entries; must be a power of two.
   localparam int CACHE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(CACHE_ENTRIES);
   localparam int TAG_W         = 24;
   localparam int LINE_W        = 1 + TAG_W + 32;

   typedef enum logic [1:0] {
      CMD_PREFETCH   = 2'd0,
      CMD_FILL       = 2'd1,
      CMD_LOAD_FETCH = 2'd2,
      CMD_LOAD_PC    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE = 2'd0,
      STATUS_FILL = 2'd1,
      STATUS_BUSY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef logic [IDX_W-1:0] index_type;
   typedef logic [TAG_W-1:0] tag_type;

   typedef struct packed {
      logic        en;
      logic        valid;
      index_type   index;
      logic        supervisor;
      tag_type     tag;
      logic [31:0] data;
   } cache_wr_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] data;
   } cache_rd_type;

   function automatic index_type line_index(input logic [31:0] addr);
      return addr[2 +: IDX_W];
   endfunction

   function automatic tag_type line_tag(input logic [31:0] addr);
      return addr[31:8];
   endfunction

   // Bit 1 of the fetch address picks the low half, otherwise the high half.
   function automatic logic [15:0] select_half(input logic [31:0] word,
                                               input logic [31:0] addr);
      return addr[1] ? word[15:0] : word[31:16];
   endfunction

endpackage

/* hdl/ipc_if.sv */
interface ipc_req_if;
   logic              valid;
   logic              ready;
   ipc_pkg::cmd_type  command;
   logic              initial_fetch;
   logic              extension_word;
   logic              increment_pc;
   logic              supervisor;
   logic [31:0]       value;

   modport source (output valid, command, initial_fetch, extension_word, increment_pc,
                   supervisor, value, input ready);
   modport sink   (input valid, command, initial_fetch, extension_word, increment_pc,
                   supervisor, value, output ready);
endinterface

interface ipc_rsp_if;
   logic                 valid;
   logic                 ready;
   ipc_pkg::status_type  status;
   logic                 cache_hit;
   logic [31:0]          fill_address;
   logic [15:0]          stage_b_word;
   logic [15:0]          stage_c_word;
   logic [15:0]          stage_d_word;
   logic [31:0]          program_counter;

   modport source (output valid, status, cache_hit, fill_address, stage_b_word, stage_c_word,
                   stage_d_word, program_counter, input ready);
   modport sink   (input valid, status, cache_hit, fill_address, stage_b_word, stage_c_word,
                   stage_d_word, program_counter, output ready);
endinterface

interface ipc_csr_if;
   logic valid;
   logic ready;
   logic cache_freeze;

   modport source (output valid, cache_freeze, input ready);
   modport sink   (input valid, cache_freeze, output ready);
endinterface

/* hdl/ipc_ram.sv */
module ipc_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/ipc_cache.sv */
`include "instruction_prefetch_with_cache_defines.svh"

module ipc_cache (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  ipc_pkg::index_type    rd_index,
   input  ipc_pkg::tag_type      cmp_tag,
   input  logic                  cmp_supervisor,
   input  ipc_pkg::cache_wr_type wr,
   output ipc_pkg::cache_rd_type rd
);

   logic [ipc_pkg::CACHE_ENTRIES-1:0] valid_ff;
   logic [ipc_pkg::CACHE_ENTRIES-1:0] valid_in;
   ipc_pkg::index_type                rd_index_ff;
   ipc_pkg::index_type                rd_index_in;
   logic [ipc_pkg::LINE_W-1:0]        wr_line;
   logic [ipc_pkg::LINE_W-1:0]        rd_line;
   logic                              line_supervisor;
   ipc_pkg::tag_type                  line_tag;

   assign wr_line = {wr.supervisor, wr.tag, wr.data};

   ipc_ram #(
      .DEPTH (ipc_pkg::CACHE_ENTRIES),
      .WIDTH (ipc_pkg::LINE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.index),
      .wr_data (wr_line),
      .rd_en   (rd_en),
      .rd_addr (rd_index),
      .rd_data (rd_line)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.index] = wr.valid;
      end
      rd_index_in = rd_en ? rd_index : rd_index_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      rd_index_ff <= rd_index_in;
   end

   assign line_supervisor = rd_line[ipc_pkg::LINE_W-1];
   assign line_tag        = rd_line[32 +: ipc_pkg::TAG_W];

   // The valid bit of an entry guards its unwritten tag and data.
   assign rd.hit  = valid_ff[rd_index_ff] && (line_supervisor == cmp_supervisor) &&
                    (line_tag == cmp_tag);
   assign rd.data = rd_line[31:0];

   `IPC_ASSERT_ALWAYS(a_no_rw_overlap, clock, reset, !(wr.en && rd_en), "cache read and write in one cycle")

endmodule

/* hdl/instruction_prefetch_with_cache.sv */
// Channel  Direction  Transfer carries
// -------  ---------  -----------------------------------------------------------
// req_if   in         command, initial_fetch, extension_word, increment_pc,
//                     supervisor, value
// rsp_if   out        status, cache_hit, fill_address, stage B/C/D words,
//                     program_counter
// csr_if   in         cache_freeze
//
// A prefetch that looks up the cache passes through the lookup state, as the cache
// memory read is registered; every other command yields its result when accepted.
// A new request is taken outside a lookup once the previous result has left the
// output register or leaves it in the same cycle.
// Reset is synchronous and clears the valid bits, the queue, the addresses and
// the fill state at once; no clearing pass runs.
// A stalled result holds in the output register until the sink takes it.
`include "instruction_prefetch_with_cache_defines.svh"

module instruction_prefetch_with_cache (
   input logic      clock,
   input logic      reset,
   ipc_req_if.sink  req_if,
   ipc_rsp_if.source rsp_if,
   ipc_csr_if.sink  csr_if
);

   // Sequencer state.
   ipc_pkg::state_type state_ff, state_in;

   // Prefetch queue and address state.
   logic [31:0] holding_ff, holding_in;
   logic [15:0] stage_b_ff, stage_b_in;
   logic [15:0] stage_c_ff, stage_c_in;
   logic [15:0] stage_d_ff, stage_d_in;
   logic [31:0] fetch_ff, fetch_in;
   logic [31:0] pc_ff, pc_in;
   logic        pending_ff, pending_in;
   logic        freeze_ff, freeze_in;
   logic        sup_ff, sup_in;

   // Result register. The stage words and the program counter are read straight from
   // the queue registers, which change only on an accepted item or when its lookup hits.
   logic                rsp_valid_ff, rsp_valid_in;
   ipc_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [31:0]         rsp_fill_ff, rsp_fill_in;

   logic                  req_ready;
   logic                  accept;
   logic                  needs_lookup;
   logic                  rd_en;
   ipc_pkg::cache_wr_type cache_wr;
   ipc_pkg::cache_rd_type cache_rd;

   // The request side may proceed outside a lookup once the output register is free
   // or is emptied by a transfer in this same cycle.
   assign req_ready = (state_ff == ipc_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept    = req_if.valid && req_ready;

   // A prefetch with no miss outstanding reads the cache unless, outside an initial
   // fetch, the second half of the holding word already supplies the next instruction word.
   assign needs_lookup = (req_if.command == ipc_pkg::CMD_PREFETCH) && !pending_ff &&
                         (req_if.initial_fetch || (fetch_ff[1:0] != 2'b10));

   ipc_cache u_cache (
      .clock          (clock),
      .reset          (reset),
      .rd_en          (rd_en),
      .rd_index       (ipc_pkg::line_index(fetch_ff)),
      .cmp_tag        (ipc_pkg::line_tag(fetch_ff)),
      .cmp_supervisor (sup_ff),
      .wr             (cache_wr),
      .rd             (cache_rd)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ipc_pkg::ST_IDLE: begin
            if (accept && needs_lookup) begin
               state_in = ipc_pkg::ST_LOOKUP;
            end
         end
         ipc_pkg::ST_LOOKUP: begin
            state_in = ipc_pkg::ST_IDLE;
         end
         default: begin
            state_in = ipc_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath updates and result register.
   always_comb begin
      holding_in    = holding_ff;
      stage_b_in    = stage_b_ff;
      stage_c_in    = stage_c_ff;
      stage_d_in    = stage_d_ff;
      fetch_in      = fetch_ff;
      pc_in         = pc_ff;
      pending_in    = pending_ff;
      sup_in        = sup_ff;
      freeze_in     = (csr_if.valid) ? csr_if.cache_freeze : freeze_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_fill_in   = rsp_fill_ff;
      rd_en         = 1'b0;
      cache_wr      = '0;

      unique case (state_ff)
         ipc_pkg::ST_IDLE: begin
            if (accept) begin
               // Every item yields a result now except a prefetch that must wait
               // for its cache read.
               rsp_valid_in  = !needs_lookup;
               rsp_status_in = ipc_pkg::STATUS_DONE;
               rsp_hit_in    = 1'b0;
               rsp_fill_in   = '0;
               if (req_if.command == ipc_pkg::CMD_FILL) begin
                  // A fill returned without an outstanding miss is dropped.
                  if (pending_ff) begin
                     cache_wr.en         = 1'b1;
                     cache_wr.valid      = !freeze_ff;
                     cache_wr.index      = ipc_pkg::line_index(fetch_ff);
                     cache_wr.supervisor = req_if.supervisor;
                     cache_wr.tag        = ipc_pkg::line_tag(fetch_ff);
                     cache_wr.data       = req_if.value;
                     holding_in          = req_if.value;
                     stage_b_in          = ipc_pkg::select_half(req_if.value, fetch_ff);
                     fetch_in            = fetch_ff + 32'd2;
                     pending_in          = 1'b0;
                  end
               end else if (pending_ff) begin
                  rsp_status_in = ipc_pkg::STATUS_BUSY;
               end else begin
                  unique case (req_if.command)
                     ipc_pkg::CMD_LOAD_FETCH: begin
                        fetch_in = req_if.value;
                     end
                     ipc_pkg::CMD_LOAD_PC: begin
                        pc_in = req_if.value;
                     end
                     default: begin
                        // Prefetch: the counter and the queue shift happen now,
                        // whether or not the lookup later hits.
                        if (req_if.increment_pc) begin
                           pc_in = pc_ff + 32'd2;
                        end
                        if (!req_if.extension_word) begin
                           stage_d_in = stage_c_ff;
                        end
                        stage_c_in = stage_b_ff;
                        if (needs_lookup) begin
                           rd_en  = 1'b1;
                           sup_in = req_if.supervisor;
                        end else begin
                           stage_b_in = holding_ff[15:0];
                           fetch_in   = fetch_ff + 32'd2;
                        end
                     end
                  endcase
               end
            end
         end
         ipc_pkg::ST_LOOKUP: begin
            rsp_valid_in = 1'b1;
            rsp_hit_in   = cache_rd.hit;
            if (cache_rd.hit) begin
               rsp_status_in = ipc_pkg::STATUS_DONE;
               rsp_fill_in   = '0;
               holding_in    = cache_rd.data;
               stage_b_in    = ipc_pkg::select_half(cache_rd.data, fetch_ff);
               fetch_in      = fetch_ff + 32'd2;
            end else begin
               rsp_status_in = ipc_pkg::STATUS_FILL;
               rsp_fill_in   = {fetch_ff[31:2], 2'b00};
               pending_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ipc_pkg::ST_IDLE;
         holding_ff   <= '0;
         stage_b_ff   <= '0;
         stage_c_ff   <= '0;
         stage_d_ff   <= '0;
         fetch_ff     <= '0;
         pc_ff        <= '0;
         pending_ff   <= 1'b0;
         freeze_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         holding_ff   <= holding_in;
         stage_b_ff   <= stage_b_in;
         stage_c_ff   <= stage_c_in;
         stage_d_ff   <= stage_d_in;
         fetch_ff     <= fetch_in;
         pc_ff        <= pc_in;
         pending_ff   <= pending_in;
         freeze_ff    <= freeze_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sup_ff        <= sup_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign req_if.ready = req_ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_status_ff;
   assign rsp_if.cache_hit       = rsp_hit_ff;
   assign rsp_if.fill_address    = rsp_fill_ff;
   assign rsp_if.stage_b_word    = stage_b_ff;
   assign rsp_if.stage_c_word    = stage_c_ff;
   assign rsp_if.stage_d_word    = stage_d_ff;
   assign rsp_if.program_counter = pc_ff;

   `IPC_ASSERT_IMPLIES(a_lookup_out_empty, clock, reset, state_ff == ipc_pkg::ST_LOOKUP, !rsp_valid_ff, "lookup with a result still held")
   `IPC_ASSERT_NEXT(a_lookup_gives_result, clock, reset, state_ff == ipc_pkg::ST_LOOKUP, rsp_valid_ff, "lookup ended without a result")
   `IPC_ASSERT_IMPLIES(a_fill_status_pending, clock, reset, rsp_valid_ff && (rsp_status_ff == ipc_pkg::STATUS_FILL), pending_ff, "fill requested but no miss outstanding")

endmodule
